// ===== rtl/polar_cost_grid_engine_top_defines.svh =====
// Assertion macros for the polar cost grid engine checker.
`ifndef POLAR_COST_GRID_ENGINE_TOP_DEFINES_SVH
`define POLAR_COST_GRID_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PCGE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("polar cost grid engine: same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define PCGE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("polar cost grid engine: next-cycle check failed");

`endif

// ===== rtl/pcge_pkg.sv =====
// Types and constants of the polar cost grid engine.
`default_nettype none
package pcge_pkg;

   typedef enum logic [2:0] {
      KIND_WRITE  = 3'd0,
      KIND_READ   = 3'd1,
      KIND_CLEAR  = 3'd2,
      KIND_DOWN   = 3'd3,
      KIND_UP     = 3'd4,
      KIND_BIN    = 3'd5,
      KIND_EMPTY  = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_RES   = 2'd1,
      ERR_RANGE = 2'd2
   } err_type;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD = 1'b1;

   localparam int ONE_Q88 = 256;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  row;
      logic [5:0]  col;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic        all_zero;
      logic        half_res;
      logic [1:0]  error;
   } rsp_type;

   typedef enum logic [1:0] {
      RS_CELL = 2'd0,
      RS_QUAD = 2'd1,
      RS_UP   = 2'd2,
      RS_CMD  = 2'd3
   } rd_sel_type;

   typedef enum logic [2:0] {
      WS_ZERO  = 3'd0,
      WS_VALUE = 3'd1,
      WS_AVG   = 3'd2,
      WS_COPY  = 3'd3,
      WS_BIN   = 3'd4
   } wr_sel_type;

   typedef enum logic [2:0] {
      CNT_HOLD     = 3'd0,
      CNT_ZERO     = 3'd1,
      CNT_TOP      = 3'd2,
      CNT_FWD_FULL = 3'd3,
      CNT_FWD_USE  = 3'd4,
      CNT_BACK     = 3'd5
   } cnt_op_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       quad_clr;
      logic       quad_inc;
      logic       acc_clr;
      logic       acc_add;
      logic       prev_init;
      logic       prev_load;
      logic       empty_init;
      logic       empty_chk;
      logic       rd_capture;
      logic       set_half;
      logic       clr_half;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       err_ok;
      logic       in_half;
      logic       in_up;
      logic       last_full;
      logic       last_use;
      logic       first;
      logic       quad_last;
      logic       rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/polar_cost_grid_engine_top.sv =====
// Top level of the polar cost grid engine.
`default_nettype none
// Polar cost grid engine: a grid of FULL_ROWS = 180/ANGLE_STEP elevation rows by
// FULL_COLS = 360/ANGLE_STEP azimuth columns of unsigned Q8.8 costs (1800 cells at
// the default step), held in one single-port-write, single-port-read RAM. One
// command beat is taken at a time; each gives exactly one result beat. After reset
// a clearing pass writes zero to every cell, one per cycle, during which req_stall
// stays high; threshold writes on the csr port are taken at any time (csr_ready is
// always high), but should only be made while the engine is idle. Work from
// acceptance to a loaded result, with the one RAM read port and the one write port:
//   write, empty-slot kinds and resolution errors: at most one write, no scan
//   read: one RAM read, then the read value is captured
//   clear: one zero write per cell over all N = FULL_ROWS*FULL_COLS cells
//   downsample: over the H half-resolution cells, a setup step, four reads and
//     one write per averaged cell, and one write per zeroed cell
//   upsample: a read and a write per cell in the even part of the full grid,
//     one write per other cell
//   binarize and empty check: a read and a write or check per cell in use
// A result waits in the output register while rsp_stall is high; the engine
// finishes the next command's work behind it and holds only at final delivery.
module polar_cost_grid_engine_top import pcge_pkg::*; #(
   parameter int ANGLE_STEP  = 6,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   // Thresholds are plain registers: every csr beat lands at once.
   assign csr_ready = 1'b1;

   pcge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcge_dpath #(
      .ANGLE_STEP  (ANGLE_STEP),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire

// ===== rtl/pcge_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcge_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1800
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pcge_dpath.sv =====
// Datapath: grid store, scan counters, accumulator, thresholds and result register.
`default_nettype none
module pcge_dpath import pcge_pkg::*; #(
   parameter int ANGLE_STEP  = 6,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire req_type                req_data,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_wdata,
   input  wire cmd_type                cmd,
   output status_type                  sts
);

   localparam int FULL_ROWS  = 180 / ANGLE_STEP;
   localparam int FULL_COLS  = 360 / ANGLE_STEP;
   localparam int HALF_ROWS  = FULL_ROWS / 2;
   localparam int HALF_COLS  = FULL_COLS / 2;
   localparam int CELL_COUNT = FULL_ROWS * FULL_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(FULL_ROWS);
   localparam int COL_W      = $clog2(FULL_COLS);
   localparam int ACC_W      = WEIGHT_BITS + 2;
   localparam logic [WEIGHT_BITS-1:0] ONE_W = WEIGHT_BITS'(ONE_Q88);

   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [1:0]             quad_ff, quad_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [WEIGHT_BITS-1:0] prev_ff, prev_in;
   logic                   half_ff, half_in;
   logic                   empty_ff, empty_in;
   logic [15:0]            rdval_ff, rdval_in;
   err_type                err_ff, err_in;
   req_type                cmd_ff, cmd_in;
   logic [15:0]            lo_ff, lo_in;
   logic [15:0]            hi_ff, hi_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]      rd_addr, wr_addr;
   logic [WEIGHT_BITS-1:0] rd_data, wr_data, bin_value;
   logic [ACC_W-1:0]       avg_sum;
   int                     rows_use, cols_use;
   logic                   cmd_in_range;

   function automatic logic [ADDR_W-1:0] cell_addr(input int r, input int c);
      return ADDR_W'(r * FULL_COLS + c);
   endfunction

   assign rows_use = half_ff ? HALF_ROWS : FULL_ROWS;
   assign cols_use = half_ff ? HALF_COLS : FULL_COLS;

   // Range check for the beat being captured.
   assign cmd_in_range = (32'(req_data.row) < rows_use) && (32'(req_data.col) < cols_use);

   always_comb begin
      case (cmd.rd_sel)
         RS_QUAD: rd_addr = cell_addr(int'(row_ff) * 2 + int'(quad_ff[1]),
                                      int'(col_ff) * 2 + int'(quad_ff[0]));
         RS_UP:   rd_addr = cell_addr(int'(row_ff) / 2, int'(col_ff) / 2);
         RS_CMD:  rd_addr = cell_addr(int'(cmd_ff.row), int'(cmd_ff.col));
         default: rd_addr = cell_addr(int'(row_ff), int'(col_ff));
      endcase
   end

   always_comb begin
      if (32'(rd_data) > 32'(hi_ff)) begin
         bin_value = ONE_W;
      end else if (32'(rd_data) < 32'(lo_ff)) begin
         bin_value = '0;
      end else begin
         bin_value = prev_ff;
      end
   end

   assign avg_sum = acc_ff + ACC_W'(rd_data);

   always_comb begin
      wr_addr = cell_addr(int'(row_ff), int'(col_ff));
      case (cmd.wr_sel)
         WS_VALUE: begin
            wr_addr = cell_addr(int'(cmd_ff.row), int'(cmd_ff.col));
            wr_data = WEIGHT_BITS'(cmd_ff.value);
         end
         WS_AVG:   wr_data = avg_sum[ACC_W-1:2];
         WS_COPY:  wr_data = rd_data;
         WS_BIN:   wr_data = bin_value;
         default:  wr_data = '0;
      endcase
   end

   pcge_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (CELL_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      case (cmd.cnt_op)
         CNT_ZERO: begin
            row_in = '0;
            col_in = '0;
         end
         CNT_TOP: begin
            row_in = ROW_W'(FULL_ROWS - 1);
            col_in = COL_W'(FULL_COLS - 1);
         end
         CNT_FWD_FULL: begin
            if (32'(col_ff) == FULL_COLS - 1) begin
               col_in = '0;
               row_in = (32'(row_ff) == FULL_ROWS - 1) ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         CNT_FWD_USE: begin
            if (32'(col_ff) == cols_use - 1) begin
               col_in = '0;
               row_in = (32'(row_ff) == rows_use - 1) ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         CNT_BACK: begin
            if (col_ff == '0) begin
               col_in = COL_W'(FULL_COLS - 1);
               row_in = (row_ff == '0) ? ROW_W'(FULL_ROWS - 1) : row_ff - ROW_W'(1);
            end else begin
               col_in = col_ff - COL_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      quad_in  = quad_ff;
      acc_in   = acc_ff;
      prev_in  = prev_ff;
      half_in  = half_ff;
      empty_in = empty_ff;
      rdval_in = rdval_ff;
      err_in   = err_ff;
      cmd_in   = cmd_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;

      if (cmd.quad_clr) quad_in = '0;
      else if (cmd.quad_inc) quad_in = quad_ff + 2'd1;

      // The first quad read has no data back yet.
      if (cmd.acc_clr) acc_in = '0;
      else if (cmd.acc_add && quad_ff != 2'd0) acc_in = avg_sum;

      if (cmd.prev_init) prev_in = ONE_W;
      else if (cmd.prev_load) prev_in = bin_value;

      if (cmd.set_half) half_in = 1'b1;
      else if (cmd.clr_half) half_in = 1'b0;

      if (cmd.empty_init) empty_in = 1'b1;
      else if (cmd.empty_chk && rd_data != '0) empty_in = 1'b0;

      if (cmd.rd_capture && err_ff == ERR_OK) rdval_in = 16'(rd_data);

      if (cmd.capture) begin
         cmd_in   = req_data;
         rdval_in = '0;
         empty_in = 1'b0;
         case (req_data.kind)
            KIND_WRITE, KIND_READ: err_in = cmd_in_range ? ERR_OK : ERR_RANGE;
            KIND_DOWN:             err_in = half_ff ? ERR_RES : ERR_OK;
            KIND_UP:               err_in = half_ff ? ERR_OK : ERR_RES;
            default:               err_in = ERR_OK;
         endcase
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_LOW_THRESHOLD:  lo_in = csr_wdata;
            CSR_HIGH_THRESHOLD: hi_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.read_value = rdval_ff;
         rsp_data_in.all_zero   = empty_ff;
         rsp_data_in.half_res   = half_ff;
         rsp_data_in.error      = err_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         quad_ff      <= '0;
         half_ff      <= 1'b0;
         lo_ff        <= 16'h0000;
         hi_ff        <= 16'hFFFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         quad_ff      <= quad_in;
         half_ff      <= half_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      prev_ff     <= prev_in;
      empty_ff    <= empty_in;
      rdval_ff    <= rdval_in;
      err_ff      <= err_in;
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.kind      = cmd_ff.kind;
   assign sts.err_ok    = (err_ff == ERR_OK);
   assign sts.in_half   = (32'(row_ff) < HALF_ROWS) && (32'(col_ff) < HALF_COLS);
   assign sts.in_up     = (32'(row_ff) < 2 * HALF_ROWS) && (32'(col_ff) < 2 * HALF_COLS);
   assign sts.last_full = (32'(row_ff) == FULL_ROWS - 1) && (32'(col_ff) == FULL_COLS - 1);
   assign sts.last_use  = (32'(row_ff) == rows_use - 1) && (32'(col_ff) == cols_use - 1);
   assign sts.first     = (row_ff == '0) && (col_ff == '0);
   assign sts.quad_last = (quad_ff == 2'd3);
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

// ===== rtl/pcge_ctrl.sv =====
// Controller: command sequencer for the grid datapath.
`default_nettype none
module pcge_ctrl import pcge_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type sts,
   output cmd_type         cmd
);

   typedef enum logic [14:0] {
      ST_INIT    = 15'h0001,
      ST_IDLE    = 15'h0002,
      ST_DECODE  = 15'h0004,
      ST_RD2     = 15'h0008,
      ST_CLR     = 15'h0010,
      ST_DS_CELL = 15'h0020,
      ST_DS_RD   = 15'h0040,
      ST_DS_WR   = 15'h0080,
      ST_US_CELL = 15'h0100,
      ST_US_WR   = 15'h0200,
      ST_BN_RD   = 15'h0400,
      ST_BN_WR   = 15'h0800,
      ST_EM_RD   = 15'h1000,
      ST_EM_CHK  = 15'h2000,
      ST_FIN     = 15'h4000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WS_ZERO;
            cmd.cnt_op = CNT_FWD_FULL;
            if (sts.last_full) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FIN;
            case (sts.kind)
               KIND_WRITE: begin
                  cmd.wr_en  = sts.err_ok;
                  cmd.wr_sel = WS_VALUE;
               end
               KIND_READ: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RS_CMD;
                  state_in   = ST_RD2;
               end
               KIND_CLEAR: begin
                  cmd.cnt_op = CNT_ZERO;
                  state_in   = ST_CLR;
               end
               KIND_DOWN: begin
                  if (sts.err_ok) begin
                     cmd.cnt_op = CNT_ZERO;
                     state_in   = ST_DS_CELL;
                  end
               end
               KIND_UP: begin
                  if (sts.err_ok) begin
                     cmd.cnt_op = CNT_TOP;
                     state_in   = ST_US_CELL;
                  end
               end
               KIND_BIN: begin
                  cmd.cnt_op    = CNT_ZERO;
                  cmd.prev_init = 1'b1;
                  state_in      = ST_BN_RD;
               end
               KIND_EMPTY: begin
                  cmd.cnt_op     = CNT_ZERO;
                  cmd.empty_init = 1'b1;
                  state_in       = ST_EM_RD;
               end
               default: ;
            endcase
         end
         ST_RD2: begin
            cmd.rd_capture = 1'b1;
            state_in       = ST_FIN;
         end
         ST_CLR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WS_ZERO;
            cmd.cnt_op = CNT_FWD_FULL;
            if (sts.last_full) state_in = ST_FIN;
         end
         ST_DS_CELL: begin
            if (sts.in_half) begin
               cmd.acc_clr  = 1'b1;
               cmd.quad_clr = 1'b1;
               state_in     = ST_DS_RD;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WS_ZERO;
               cmd.cnt_op = CNT_FWD_FULL;
               if (sts.last_full) begin
                  cmd.set_half = 1'b1;
                  state_in     = ST_FIN;
               end
            end
         end
         ST_DS_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RS_QUAD;
            cmd.acc_add  = 1'b1;
            cmd.quad_inc = 1'b1;
            if (sts.quad_last) state_in = ST_DS_WR;
         end
         ST_DS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WS_AVG;
            cmd.cnt_op = CNT_FWD_FULL;
            state_in   = ST_DS_CELL;
         end
         ST_US_CELL: begin
            if (sts.in_up) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RS_UP;
               state_in   = ST_US_WR;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WS_ZERO;
               cmd.cnt_op = CNT_BACK;
               if (sts.first) begin
                  cmd.clr_half = 1'b1;
                  state_in     = ST_FIN;
               end
            end
         end
         ST_US_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WS_COPY;
            cmd.cnt_op = CNT_BACK;
            if (sts.first) begin
               cmd.clr_half = 1'b1;
               state_in     = ST_FIN;
            end else begin
               state_in = ST_US_CELL;
            end
         end
         ST_BN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_CELL;
            state_in   = ST_BN_WR;
         end
         ST_BN_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WS_BIN;
            cmd.prev_load = 1'b1;
            cmd.cnt_op    = CNT_FWD_USE;
            state_in      = sts.last_use ? ST_FIN : ST_BN_RD;
         end
         ST_EM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_CELL;
            state_in   = ST_EM_CHK;
         end
         ST_EM_CHK: begin
            cmd.empty_chk = 1'b1;
            cmd.cnt_op    = CNT_FWD_USE;
            state_in      = sts.last_use ? ST_FIN : ST_EM_RD;
         end
         ST_FIN: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/pcge_checker.sv =====
// Port-level checker of the polar cost grid engine and its bind.
`default_nettype none
`include "polar_cost_grid_engine_top_defines.svh"
module pcge_checker import pcge_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire rsp_type rsp_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall
);

   // Hold a stalled result beat.
   `PCGE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // No error code past the list.
   `PCGE_ASSERT_IMP(a_err_code, rsp_valid, rsp_data.error != 2'd3)
   // A nonzero read value only comes with a clean result.
   `PCGE_ASSERT_IMP(a_read_ok, rsp_valid && rsp_data.read_value != 16'd0,
                    rsp_data.error == 2'd0 && !rsp_data.all_zero)
   // Empty only on a clean result with no read value.
   `PCGE_ASSERT_IMP(a_empty_ok, rsp_valid && rsp_data.all_zero,
                    rsp_data.error == 2'd0 && rsp_data.read_value == 16'd0)
   // Hold off the next command beat right after one is taken.
   `PCGE_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall)

endmodule

bind polar_cost_grid_engine_top pcge_checker u_checker (.*);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the polar cost grid engine: directed table, then random beats.
`default_nettype none
module tb_top;
   import pcge_pkg::*;

   localparam int FULL_ROWS = 30;
   localparam int FULL_COLS = 60;
   localparam int CELLS     = FULL_ROWS * FULL_COLS;
   // Kind 7 is not decoded by the engine; it must answer with no read value, no empty flag and no error.
   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam logic [15:0] Q88_ONE = 16'(ONE_Q88);

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0] csr_wdata;

   polar_cost_grid_engine_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the grid, the resolution flag and both thresholds.
   logic [15:0] grid_shadow [CELLS];
   logic        half_shadow;
   logic [15:0] low_thr;
   logic [15:0] high_thr;

   rsp_type pending_rsp[$];
   int      fail_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one command to the shadow grid and return the beat it must produce.
   function automatic rsp_type grid_apply(req_type cmd);
      rsp_type res;
      logic [15:0] tmp [CELLS];
      logic [17:0] sum;
      logic [15:0] prev;
      logic [15:0] cur;
      int nr;
      int nc;
      res = '0;
      nr = half_shadow ? FULL_ROWS / 2 : FULL_ROWS;
      nc = half_shadow ? FULL_COLS / 2 : FULL_COLS;
      case (cmd.kind)
         KIND_WRITE, KIND_READ: begin
            if (cmd.row >= nr || cmd.col >= nc)
               res.error = ERR_RANGE;
            else if (cmd.kind == KIND_WRITE)
               grid_shadow[cmd.row * FULL_COLS + cmd.col] = cmd.value;
            else
               res.read_value = grid_shadow[cmd.row * FULL_COLS + cmd.col];
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CELLS; i++) grid_shadow[i] = '0;
         end
         KIND_DOWN: begin
            if (half_shadow) begin
               res.error = ERR_RES;
            end else begin
               for (int i = 0; i < CELLS; i++) tmp[i] = '0;
               for (int r = 0; r < FULL_ROWS / 2; r++)
                  for (int c = 0; c < FULL_COLS / 2; c++) begin
                     sum = 18'(grid_shadow[2*r*FULL_COLS + 2*c])
                         + 18'(grid_shadow[2*r*FULL_COLS + 2*c + 1])
                         + 18'(grid_shadow[(2*r+1)*FULL_COLS + 2*c])
                         + 18'(grid_shadow[(2*r+1)*FULL_COLS + 2*c + 1]);
                     tmp[r*FULL_COLS + c] = sum[17:2];
                  end
               grid_shadow = tmp;
               half_shadow = 1'b1;
            end
         end
         KIND_UP: begin
            if (!half_shadow) begin
               res.error = ERR_RES;
            end else begin
               for (int i = 0; i < CELLS; i++) tmp[i] = '0;
               for (int r = 0; r < (FULL_ROWS / 2) * 2; r++)
                  for (int c = 0; c < (FULL_COLS / 2) * 2; c++)
                     tmp[r*FULL_COLS + c] = grid_shadow[(r/2)*FULL_COLS + c/2];
               grid_shadow = tmp;
               half_shadow = 1'b0;
            end
         end
         KIND_BIN: begin
            prev = Q88_ONE;
            for (int r = 0; r < nr; r++)
               for (int c = 0; c < nc; c++) begin
                  cur = grid_shadow[r*FULL_COLS + c];
                  if (cur > high_thr) prev = Q88_ONE;
                  else if (cur < low_thr) prev = '0;
                  grid_shadow[r*FULL_COLS + c] = prev;
               end
         end
         KIND_EMPTY: begin
            res.all_zero = 1'b1;
            for (int r = 0; r < nr; r++)
               for (int c = 0; c < nc; c++)
                  if (grid_shadow[r*FULL_COLS + c] != '0) res.all_zero = 1'b0;
         end
         default: ;
      endcase
      res.half_res = half_shadow;
      return res;
   endfunction

   // Directed table: command, and a typed-in result where it is obvious.
   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } row_type;

   function automatic row_type mk(logic [2:0] k, int r, int c, int v,
                                  bit typed = 0, int rd = 0, bit emp = 0,
                                  bit half = 0, err_type err = ERR_OK);
      row_type t;
      t.cmd   = '{kind: k, row: 5'(r), col: 6'(c), value: 16'(v)};
      t.typed = typed;
      t.want  = '{read_value: 16'(rd), all_zero: emp, half_res: half, error: err};
      return t;
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Drive one command beat; hold it until taken, then log its expected result.
   task automatic send_cmd(req_type cmd, bit typed, rsp_type want);
      rsp_type model;
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model = grid_apply(cmd);
      pending_rsp.push_back(typed ? want : model);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_LOW_THRESHOLD) low_thr = data;
      else high_thr = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type rand_cmd();
      req_type cmd;
      int p;
      p = $urandom_range(0, 99);
      cmd.kind = p < 45 ? KIND_WRITE : p < 80 ? KIND_READ : p < 82 ? KIND_CLEAR :
                 p < 86 ? KIND_DOWN : p < 90 ? KIND_UP : p < 94 ? KIND_BIN :
                 p < 98 ? KIND_EMPTY : KIND_UNUSED;
      // Keep most addresses inside the grid in use; stray the rest anywhere.
      if ($urandom_range(0, 9) < 8) begin
         cmd.row = 5'($urandom_range(0, half_shadow ? FULL_ROWS/2 - 1 : FULL_ROWS - 1));
         cmd.col = 6'($urandom_range(0, half_shadow ? FULL_COLS/2 - 1 : FULL_COLS - 1));
      end else begin
         cmd.row = 5'($urandom_range(0, 31));
         cmd.col = 6'($urandom_range(0, 63));
      end
      p = $urandom_range(0, 9);
      cmd.value = p == 0 ? 16'hFFFF : p == 1 ? 16'h0000 : 16'($urandom_range(0, 65535));
      return cmd;
   endfunction

   // Result side: random stall, compare each taken beat with the oldest expectation.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            stall_left <= gap_len();
            rsp_stall  <= 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_data.read_value !== pending_rsp[0].read_value ||
                   rsp_data.all_zero !== pending_rsp[0].all_zero ||
                   rsp_data.half_res !== pending_rsp[0].half_res ||
                   rsp_data.error !== pending_rsp[0].error) begin
                  $display("%0t: mismatch expected %p actual %p",
                           $time, pending_rsp[0], rsp_data);
                  fail_count <= fail_count + 1;
               end
               void'(pending_rsp.pop_front());
            end
         end
      end
   end

   row_type directed[$];
   logic [15:0] thr_pairs [5][2] = '{
      '{16'h0000, 16'hFFFF}, '{16'hFFFF, 16'h0000}, '{16'h0000, 16'h0000},
      '{16'hFFFF, 16'hFFFF}, '{16'h0080, 16'h0180}};

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < CELLS; i++) grid_shadow[i] = '0;
      half_shadow = 1'b0;
      low_thr = 16'h0000;
      high_thr = 16'hFFFF;

      directed = '{
         mk(KIND_EMPTY, 0, 0, 0, 1, 0, 1),
         mk(KIND_READ, 0, 0, 0, 1),
         mk(KIND_WRITE, 29, 59, 16'hFFFF, 1),
         mk(KIND_READ, 29, 59, 0, 1, 16'hFFFF),
         mk(KIND_WRITE, 30, 0, 16'h1111, 1, 0, 0, 0, ERR_RANGE),
         mk(KIND_READ, 0, 60, 0, 1, 0, 0, 0, ERR_RANGE),
         mk(KIND_WRITE, 31, 63, 0, 1, 0, 0, 0, ERR_RANGE),
         mk(KIND_UP, 0, 0, 0, 1, 0, 0, 0, ERR_RES),
         mk(KIND_WRITE, 0, 0, 1), mk(KIND_WRITE, 0, 1, 2),
         mk(KIND_WRITE, 1, 0, 3), mk(KIND_WRITE, 1, 1, 16'hFFFF),
         mk(KIND_DOWN, 0, 0, 0),
         mk(KIND_READ, 0, 0, 0),
         mk(KIND_DOWN, 0, 0, 0, 1, 0, 0, 1, ERR_RES),
         mk(KIND_READ, 15, 0, 0, 1, 0, 0, 1, ERR_RANGE),
         mk(KIND_WRITE, 14, 29, 16'h1234),
         mk(KIND_EMPTY, 0, 0, 0),
         mk(KIND_UP, 0, 0, 0),
         mk(KIND_READ, 29, 59, 0),
         mk(KIND_BIN, 0, 0, 0),
         mk(KIND_UNUSED, 31, 63, 16'hFFFF, 1),
         mk(KIND_CLEAR, 0, 0, 0),
         mk(KIND_EMPTY, 0, 0, 0, 1, 0, 1)};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].typed, directed[i].want);
      drain();

      // Random phases, each under a different threshold pair, extremes first.
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CSR_LOW_THRESHOLD, thr_pairs[ph][0]);
         csr_write(CSR_HIGH_THRESHOLD, thr_pairs[ph][1]);
         for (int n = 0; n < 57; n++) send_cmd(rand_cmd(), 1'b0, '0);
         drain();
      end
      csr_write(CSR_LOW_THRESHOLD, 16'($urandom_range(0, 65535)));
      csr_write(CSR_HIGH_THRESHOLD, 16'($urandom_range(0, 65535)));
      for (int n = 0; n < 20; n++) send_cmd(rand_cmd(), 1'b0, '0);
      drain();

      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Hard stop in case the engine hangs.
   initial begin
      #40000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
